// ----- hdl/lce_pkg.sv -----
package lce_pkg;

    localparam int ENTRIES  = 16;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int CAP_W    = 5;
    localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int USE_W    = 32;
    localparam int STAMP_W  = 48;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [USE_W-1:0] USE_MAX   = {USE_W{1'b1}};

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
        logic [USE_W-1:0]   use_count;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

endpackage

// ----- hdl/lce_req_if.sv -----
interface lce_req_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic [31:0]        lookup_key;
    logic signed [31:0] write_value;

    modport source (output valid, command, lookup_key, write_value, input ready);
    modport sink   (input valid, command, lookup_key, write_value, output ready);
endinterface

// ----- hdl/lce_rsp_if.sv -----
interface lce_rsp_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] read_value;

    modport source (output valid, hit, read_value, input ready);
    modport sink   (input valid, hit, read_value, output ready);
endinterface

// ----- hdl/lfu_cache_engine_unit.sv -----
// a request is taken only while idle; its scan and decide finish before the next one
// is taken
// the entry memory gives one read per cycle over all slots, then at most one write-back
// a finished result waits in the output register while the next request is taken
// reset: synchronous active low; clears valid bits, occupancy, stamp counter,
// capacity to 16; entry memory contents are not cleared
module lfu_cache_engine_unit
    import lce_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    lce_req_if.sink          i_req,
    lce_rsp_if.source        o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } t_state;

    t_entry r_mem [ENTRIES];
    t_entry r_rdata;

    t_state               r_state, n_state;
    logic [CAP_W-1:0]     r_capacity, n_capacity;
    logic [ENTRIES-1:0]   r_valid, n_valid;
    logic [CNT_W-1:0]     r_occ, n_occ;
    logic [STAMP_W-1:0]   r_stamp, n_stamp;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]     r_cmp_idx, n_cmp_idx;
    logic                 r_cmd, n_cmd;
    logic [KEY_W-1:0]     r_key, n_key;
    logic [VAL_W-1:0]     r_wval, n_wval;
    logic                 r_found, n_found;
    logic [IDX_W-1:0]     r_found_idx, n_found_idx;
    t_entry               r_found_ent, n_found_ent;
    logic                 r_free, n_free;
    logic [IDX_W-1:0]     r_free_idx, n_free_idx;
    logic                 r_vic, n_vic;
    logic [IDX_W-1:0]     r_vic_idx, n_vic_idx;
    logic [USE_W-1:0]     r_vic_cnt, n_vic_cnt;
    logic [STAMP_W-1:0]   r_vic_stamp, n_vic_stamp;
    logic                 r_o_valid, n_o_valid;
    logic                 r_o_hit, n_o_hit;
    logic [VAL_W-1:0]     r_o_value, n_o_value;

    logic                 w_en;
    logic [IDX_W-1:0]     w_idx;
    t_entry               w_data;
    logic [IDX_W-1:0]     rd_idx;
    logic [CMP_W-1:0]     cap_ext;
    logic [CMP_W-1:0]     cap_eff;
    logic                 out_free;
    logic                 full;
    logic [STAMP_W-1:0]   stamp_next;

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_o_valid;
    assign o_rsp.hit        = r_o_hit;
    assign o_rsp.read_value = r_o_value;

    assign rd_idx     = r_cnt[IDX_W-1:0];
    assign cap_ext    = CMP_W'(r_capacity);
    assign cap_eff    = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
    assign out_free   = !r_o_valid || o_rsp.ready;
    assign full       = (CMP_W'(r_occ) >= cap_eff) || !r_free;
    assign stamp_next = r_stamp + STAMP_W'(1);

    always_comb begin
        n_state     = r_state;
        n_capacity  = r_capacity;
        n_valid     = r_valid;
        n_occ       = r_occ;
        n_stamp     = r_stamp;
        n_cnt       = r_cnt;
        n_cmp_vld   = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_wval      = r_wval;
        n_found     = r_found;
        n_found_idx = r_found_idx;
        n_found_ent = r_found_ent;
        n_free      = r_free;
        n_free_idx  = r_free_idx;
        n_vic       = r_vic;
        n_vic_idx   = r_vic_idx;
        n_vic_cnt   = r_vic_cnt;
        n_vic_stamp = r_vic_stamp;
        n_o_valid   = r_o_valid && !o_rsp.ready;
        n_o_hit     = r_o_hit;
        n_o_value   = r_o_value;
        w_en        = 1'b0;
        w_idx       = r_found_idx;
        w_data      = r_found_ent;

        if (i_cfg_we) begin
            n_capacity = i_cfg_wdata;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_cmd   = i_req.command;
                    n_key   = i_req.lookup_key;
                    n_wval  = i_req.write_value;
                    n_cnt   = '0;
                    n_found = 1'b0;
                    n_free  = 1'b0;
                    n_vic   = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt != CNT_W'(ENTRIES)) begin
                    n_cnt     = r_cnt + CNT_W'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = rd_idx;
                end else if (!r_cmp_vld) begin
                    n_state = S_DECIDE;
                end
                if (r_cmp_vld) begin
                    if (r_valid[r_cmp_idx]) begin
                        if (!r_found && r_rdata.key == r_key) begin
                            n_found     = 1'b1;
                            n_found_idx = r_cmp_idx;
                            n_found_ent = r_rdata;
                        end
                        if (!r_vic || r_rdata.use_count < r_vic_cnt ||
                            (r_rdata.use_count == r_vic_cnt &&
                             r_rdata.stamp < r_vic_stamp)) begin
                            n_vic       = 1'b1;
                            n_vic_idx   = r_cmp_idx;
                            n_vic_cnt   = r_rdata.use_count;
                            n_vic_stamp = r_rdata.stamp;
                        end
                    end else if (!r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_cmp_idx;
                    end
                end
            end
            S_DECIDE: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_hit   = 1'b0;
                    n_o_value = '0;
                    n_state   = S_IDLE;
                    if (cap_eff != '0) begin
                        if (r_found) begin
                            n_o_hit = 1'b1;
                            if (r_cmd == CMD_GET) begin
                                n_o_value = r_found_ent.value;
                            end
                            w_en             = 1'b1;
                            w_idx            = r_found_idx;
                            w_data           = r_found_ent;
                            w_data.stamp     = stamp_next;
                            w_data.use_count = (r_found_ent.use_count == USE_MAX) ?
                                               USE_MAX : r_found_ent.use_count + USE_W'(1);
                            if (r_cmd == CMD_PUT) begin
                                w_data.value = r_wval;
                            end
                            n_stamp = stamp_next;
                        end else if (r_cmd == CMD_PUT && (!full || r_vic)) begin
                            w_en             = 1'b1;
                            w_idx            = full ? r_vic_idx : r_free_idx;
                            w_data.key       = r_key;
                            w_data.value     = r_wval;
                            w_data.use_count = USE_W'(1);
                            w_data.stamp     = stamp_next;
                            n_stamp          = stamp_next;
                            n_valid[w_idx]   = 1'b1;
                            if (!full) begin
                                n_occ = r_occ + CNT_W'(1);
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_idx] <= w_data;
        end
        r_rdata <= r_mem[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_capacity <= CAP_RESET;
            r_valid    <= '0;
            r_occ      <= '0;
            r_stamp    <= '0;
            r_cmp_vld  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_capacity <= n_capacity;
            r_valid    <= n_valid;
            r_occ      <= n_occ;
            r_stamp    <= n_stamp;
            r_cmp_vld  <= n_cmp_vld;
            r_o_valid  <= n_o_valid;
        end
        r_cnt       <= n_cnt;
        r_cmp_idx   <= n_cmp_idx;
        r_cmd       <= n_cmd;
        r_key       <= n_key;
        r_wval      <= n_wval;
        r_found     <= n_found;
        r_found_idx <= n_found_idx;
        r_found_ent <= n_found_ent;
        r_free      <= n_free;
        r_free_idx  <= n_free_idx;
        r_vic       <= n_vic;
        r_vic_idx   <= n_vic_idx;
        r_vic_cnt   <= n_vic_cnt;
        r_vic_stamp <= n_vic_stamp;
        r_o_hit     <= n_o_hit;
        r_o_value   <= n_o_value;
    end

    // occupancy tracks the number of valid slots
    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_occ))
        else $error("occupancy out of step with valid bits");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_SCAN && r_cnt == '0))
        else $error("request transaction did not start a scan");

    a_result_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en || $rose(r_o_valid)) |-> (r_state == S_DECIDE || $past(r_state == S_DECIDE)))
        else $error("write-back or result outside the decide step");

    a_no_write_when_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cap_eff == '0) |-> !w_en)
        else $error("entry memory written while cache disabled");

endmodule

// ----- sim/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lce_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 130;
    localparam int POOL_MAX    = ENTRIES + 4;

    typedef struct {
        logic               hit;
        logic signed [31:0] value;
    } t_cache_answer;

    typedef struct {
        bit                 is_cfg;
        logic [CAP_W-1:0]   cap;
        logic               cmd;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   val;
        bit                 typed;
        logic               exp_hit;
        logic [VAL_W-1:0]   exp_val;
    } t_plan_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CAP_W-1:0] i_cfg_wdata;

    lce_req_if req_bus ();
    lce_rsp_if rsp_bus ();

    lfu_cache_engine_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_bus),
        .o_rsp       (rsp_bus)
    );

    // shadow copy of the cache contents
    logic               slot_used  [ENTRIES];
    logic [KEY_W-1:0]   slot_key   [ENTRIES];
    logic [VAL_W-1:0]   slot_val   [ENTRIES];
    logic [USE_W-1:0]   slot_uses  [ENTRIES];
    logic [STAMP_W-1:0] slot_stamp [ENTRIES];
    logic [STAMP_W-1:0] stamp_now;
    int                 fill_level;
    logic [CAP_W-1:0]   cap_setting;

    t_cache_answer answer_q[$];

    int err_cnt = 0;
    int req_cnt = 0;
    int hit_cnt = 0;
    int cfg_cnt = 0;
    int rx_hold = 0;
    bit calm    = 1'b0;

    t_plan_row dir_plan [0:23] = '{
        '{1'b0, 5'd0,  CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{1'b0, 5'd0,  CMD_PUT, 32'h0000_0000, 32'h7fff_ffff, 1'b1, 1'b0, 32'h0000_0000},
        '{1'b0, 5'd0,  CMD_GET, 32'h0000_0000, 32'h1234_5678, 1'b1, 1'b1, 32'h7fff_ffff},
        '{1'b0, 5'd0,  CMD_PUT, 32'hffff_ffff, 32'h8000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{1'b0, 5'd0,  CMD_GET, 32'hffff_ffff, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
        '{1'b0, 5'd0,  CMD_PUT, 32'h0000_0000, 32'hffff_ffff, 1'b1, 1'b1, 32'h0000_0000},
        '{1'b0, 5'd0,  CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hffff_ffff},
        '{1'b0, 5'd0,  CMD_GET, 32'h0000_0001, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{1'b0, 5'd0,  CMD_PUT, 32'ha5a5_a5a5, 32'h5a5a_5a5a, 1'b1, 1'b0, 32'h0000_0000},
        '{1'b1, 5'd0,  CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, 5'd0,  CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{1'b0, 5'd0,  CMD_PUT, 32'h0000_0005, 32'h0000_0009, 1'b1, 1'b0, 32'h0000_0000},
        '{1'b1, 5'd31, CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, 5'd0,  CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hffff_ffff},
        '{1'b0, 5'd0,  CMD_GET, 32'h0000_0005, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{1'b1, 5'd2,  CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, 5'd0,  CMD_PUT, 32'h0000_0007, 32'h0000_0046, 1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, 5'd0,  CMD_GET, 32'hffff_ffff, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, 5'd0,  CMD_GET, 32'h0000_0007, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, 5'd0,  CMD_PUT, 32'h0000_0008, 32'h0000_0050, 1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, 5'd0,  CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{1'b1, 5'd16, CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, 5'd0,  CMD_PUT, 32'h0000_0009, 32'h0000_005a, 1'b0, 1'b0, 32'h0000_0000},
        '{1'b0, 5'd0,  CMD_GET, 32'h0000_0009, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000}
    };

    logic [CAP_W-1:0] phase_cap [PHASES] = '{
        5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd3, 5'd12, 5'd17, 5'd2, 5'd16
    };

    function automatic int cap_limit();
        return (cap_setting > ENTRIES) ? ENTRIES : int'(cap_setting);
    endfunction

    function automatic t_cache_answer cache_lookup(input logic cmd,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [VAL_W-1:0] val);
        t_cache_answer ans;
        int found;
        int free_idx;
        int victim;
        int slot;
        int lim;
        int i;
        ans.hit   = 1'b0;
        ans.value = '0;
        lim       = cap_limit();
        if (lim == 0) begin
            return ans;
        end
        found    = -1;
        free_idx = -1;
        victim   = -1;
        for (i = 0; i < ENTRIES; i++) begin
            if (slot_used[i]) begin
                if (found < 0 && slot_key[i] == key) begin
                    found = i;
                end
                if (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                    (slot_uses[i] == slot_uses[victim] &&
                     slot_stamp[i] < slot_stamp[victim])) begin
                    victim = i;
                end
            end else if (free_idx < 0) begin
                free_idx = i;
            end
        end
        if (found >= 0) begin
            if (slot_uses[found] != USE_MAX) begin
                slot_uses[found] = slot_uses[found] + 1'b1;
            end
            stamp_now          = stamp_now + 1'b1;
            slot_stamp[found]  = stamp_now;
            if (cmd == CMD_PUT) begin
                slot_val[found] = val;
            end else begin
                ans.value = slot_val[found];
            end
            ans.hit = 1'b1;
            return ans;
        end
        if (cmd == CMD_GET) begin
            return ans;
        end
        // shrunk capacity or full: replace the victim in place
        if (fill_level >= lim || free_idx < 0) begin
            slot = victim;
        end else begin
            slot       = free_idx;
            fill_level = fill_level + 1;
        end
        if (slot < 0) begin
            return ans;
        end
        stamp_now        = stamp_now + 1'b1;
        slot_used[slot]  = 1'b1;
        slot_key[slot]   = key;
        slot_val[slot]   = val;
        slot_uses[slot]  = 1;
        slot_stamp[slot] = stamp_now;
        return ans;
    endfunction

    task automatic wait_drain();
        req_bus.valid <= 1'b0;
        while (answer_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (ENTRIES + 6) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        wait_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cap_setting = cap;
        cfg_cnt++;
    endtask

    task automatic offer(input logic cmd, input logic [KEY_W-1:0] key,
                         input logic [VAL_W-1:0] val, input bit typed,
                         input logic exp_hit, input logic [VAL_W-1:0] exp_val);
        t_cache_answer ans;
        if (!calm && $urandom_range(0, 5) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.command     <= cmd;
        req_bus.lookup_key  <= key;
        req_bus.write_value <= val;
        @(posedge i_clk);
        while (!req_bus.ready) begin
            @(posedge i_clk);
        end
        ans = cache_lookup(cmd, key, val);
        req_cnt++;
        if (ans.hit) begin
            hit_cnt++;
        end
        if (typed) begin
            ans.hit   = exp_hit;
            ans.value = exp_val;
        end
        answer_q.push_back(ans);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // result side
    initial begin
        t_cache_answer want;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (answer_q.size() == 0) begin
                    $error("unexpected transaction: hit %0b read_value %0d",
                           rsp_bus.hit, rsp_bus.read_value);
                    err_cnt++;
                end else begin
                    want = answer_q.pop_front();
                    if (rsp_bus.hit !== want.hit) begin
                        $error("hit: expected %0b, actual %0b", want.hit, rsp_bus.hit);
                        err_cnt++;
                    end
                    if (rsp_bus.read_value !== want.value) begin
                        $error("read_value: expected %0d, actual %0d",
                               want.value, rsp_bus.read_value);
                        err_cnt++;
                    end
                end
            end
            if (rx_hold > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (rx_hold) @(posedge i_clk);
                rx_hold = 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
        end
    end

    // request side
    initial begin
        logic [KEY_W-1:0] key_pool [POOL_MAX];
        logic [KEY_W-1:0] key;
        int               pool_n;
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_wdata         <= '0;
        req_bus.valid       <= 1'b0;
        req_bus.command     <= CMD_GET;
        req_bus.lookup_key  <= '0;
        req_bus.write_value <= '0;
        foreach (slot_used[i]) begin
            slot_used[i] = 1'b0;
        end
        stamp_now   = '0;
        fill_level  = 0;
        cap_setting = CAP_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_plan[r]) begin
            if (dir_plan[r].is_cfg) begin
                set_capacity(dir_plan[r].cap);
            end else begin
                offer(dir_plan[r].cmd, dir_plan[r].key, dir_plan[r].val,
                      dir_plan[r].typed, dir_plan[r].exp_hit, dir_plan[r].exp_val);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            set_capacity(phase_cap[p]);
            calm   = (p == PHASES - 1);
            pool_n = cap_limit() + 3;
            if (pool_n < 8) begin
                pool_n = 8;
            end
            for (int k = 0; k < pool_n; k++) begin
                key_pool[k] = $urandom;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == 40) begin
                    rx_hold = HOLD_CYCLES;
                end
                if ($urandom_range(0, 9) == 0) begin
                    key = $urandom;
                end else begin
                    key = key_pool[$urandom_range(0, pool_n - 1)];
                end
                offer(logic'($urandom_range(0, 1)), key, $urandom, 1'b0, 1'b0, '0);
            end
        end

        wait_drain();
        $display("tb: %0d requests, %0d hits, %0d capacity writes",
                 req_cnt, hit_cnt, cfg_cnt);
        $display("tb: covered disabled cache, oversize and shrunk capacity, %0d-cycle stall",
                 HOLD_CYCLES);
        if (err_cnt == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- lfu_cache_engine_unit.f -----
hdl/lce_pkg.sv
hdl/lce_req_if.sv
hdl/lce_rsp_if.sv
hdl/lfu_cache_engine_unit.sv
sim/tb.sv
